/* design/sfd_pkg.sv */
// Shared types and constants for the S.BUS frame decoder.
package sfd_pkg;

    localparam int FRAME_LENGTH     = 25;
    localparam int THROTTLE_CHANNEL = 2;
    localparam int NUM_CH           = 18;
    localparam int NUM_PACKED_CH    = 16;
    localparam int CH_W             = 11;
    localparam int SCALED_W         = 12;
    localparam int CNT_W            = 32;
    localparam int IDX_W            = 5;
    localparam int POS_W            = 5;
    localparam int FLAG_BYTE        = 23;
    localparam int LAST_POS         = FRAME_LENGTH - 1;
    localparam int LAST_CH          = NUM_CH - 1;

    localparam int SCALE_W          = 16;
    localparam int OFFSET_W         = 12;
    localparam int THROTTLE_W       = 12;
    localparam int TIMEOUT_W        = 16;
    localparam int FRAC_BITS        = 12;

    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;

    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_AW         = 1;

    localparam logic [7:0]            START_BYTE     = 8'h0F;
    localparam logic [CH_W-1:0]       CH_MAX         = 11'h7FF;
    localparam logic [SCALE_W-1:0]    RST_SCALE      = 16'd2560;
    localparam logic [OFFSET_W-1:0]   RST_OFFSET     = 12'd880;
    localparam logic [THROTTLE_W-1:0] RST_THROTTLE   = 12'd900;
    localparam logic [TIMEOUT_W-1:0]  RST_TIMEOUT    = 16'd500;

    localparam logic CAUSE_FRAME   = 1'b0;
    localparam logic CAUSE_TIMEOUT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_FACTOR     = 2'd0,
        CFG_SCALE_OFFSET     = 2'd1,
        CFG_FAILSAFE_THROTTLE = 2'd2,
        CFG_TIMEOUT_MS       = 2'd3
    } t_cfg_reg;

    typedef logic [CH_W-1:0] t_chan;
    typedef t_chan [NUM_CH-1:0] t_chan_vec;

    typedef struct packed {
        t_chan_vec          ch;
        logic               failsafe;
        logic               lost;
        logic [CNT_W-1:0]   good;
        logic [CNT_W-1:0]   lostc;
        logic [CNT_W-1:0]   err;
        logic               cause;
    } t_event;

    typedef struct packed {
        logic [SCALE_W-1:0]    scale;
        logic [OFFSET_W-1:0]   offset;
        logic [THROTTLE_W-1:0] throttle;
    } t_scale_cfg;

endpackage

/* design/sfd_in_if.sv */
// Input item channel: received byte or millisecond tick.
interface sfd_in_if import sfd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source(output valid, output mode, output rx_byte, input ready);
    modport sink(input valid, input mode, input rx_byte, output ready);
endinterface

/* design/sfd_out_if.sv */
// Result item channel: one decoded channel per item.
interface sfd_out_if import sfd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    channel_index;
    logic [CH_W-1:0]     raw_value;
    logic [SCALED_W-1:0] scaled_value;
    logic                failsafe_active;
    logic                frame_lost_flag;
    logic [CNT_W-1:0]    good_count;
    logic [CNT_W-1:0]    lost_count;
    logic [CNT_W-1:0]    error_count;
    logic                cause;
    logic                last_of_run;

    modport source(output valid, output channel_index, output raw_value, output scaled_value,
                   output failsafe_active, output frame_lost_flag, output good_count,
                   output lost_count, output error_count, output cause,
                   output last_of_run, input ready);
    modport sink(input valid, input channel_index, input raw_value, input scaled_value,
                 input failsafe_active, input frame_lost_flag, input good_count,
                 input lost_count, input error_count, input cause,
                 input last_of_run, output ready);
endinterface

/* design/sfd_front.sv */
// Front end: frame assembly, decode, counters and timeout, emits run events.
module sfd_front import sfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sfd_in_if.sink               i_in,
    input  logic [TIMEOUT_W-1:0] i_timeout_ms,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_event               o_evt
);

    logic [POS_W-1:0]     r_pos,      n_pos;
    t_chan_vec            r_ch,       n_ch;
    logic                 r_fs,       n_fs;
    logic                 r_lost,     n_lost;
    logic [TIMEOUT_W-1:0] r_elapsed,  n_elapsed;
    logic                 r_reported, n_reported;
    logic [CNT_W-1:0]     r_good,     n_good;
    logic [CNT_W-1:0]     r_lostc,    n_lostc;
    logic [CNT_W-1:0]     r_err,      n_err;
    logic [7:0]           r_frame [LAST_POS];

    logic                          w_acc;
    logic                          w_cause;
    logic                          w_end_ok;
    logic                          w_bad_start;
    logic                          w_store;
    logic [NUM_PACKED_CH*CH_W-1:0] w_data;
    logic [7:0]                    w_flags;
    t_chan_vec                     w_dec;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    assign i_in.ready  = !i_q_full;
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_bad_start = (r_pos == '0) && (i_in.rx_byte != START_BYTE);
    assign w_store     = w_acc && !i_in.mode && !w_bad_start && (r_pos != POS_W'(LAST_POS));
    assign w_flags     = r_frame[FLAG_BYTE];
    assign w_end_ok    = (i_in.rx_byte[3:0] == 4'h0 && i_in.rx_byte[7:4] == 4'h0)
                      || (i_in.rx_byte[4:0] == 5'b00011);

    always_comb begin
        for (int k = 1; k <= NUM_PACKED_CH * CH_W / 8; k++) begin
            w_data[(k-1)*8 +: 8] = r_frame[k];
        end
        for (int i = 0; i < NUM_PACKED_CH; i++) begin
            w_dec[i] = w_data[i*CH_W +: CH_W];
        end
        w_dec[NUM_PACKED_CH]   = w_flags[0] ? CH_MAX : '0;
        w_dec[NUM_PACKED_CH+1] = w_flags[1] ? CH_MAX : '0;
    end

    always_comb begin
        n_pos      = r_pos;
        n_ch       = r_ch;
        n_fs       = r_fs;
        n_lost     = r_lost;
        n_elapsed  = r_elapsed;
        n_reported = r_reported;
        n_good     = r_good;
        n_lostc    = r_lostc;
        n_err      = r_err;
        o_push     = 1'b0;
        w_cause    = CAUSE_FRAME;
        if (w_acc) begin
            if (i_in.mode) begin
                n_elapsed = (r_elapsed == {TIMEOUT_W{1'b1}}) ? r_elapsed : r_elapsed + 1'b1;
                if (n_elapsed > i_timeout_ms && !r_reported) begin
                    n_reported = 1'b1;
                    n_fs       = 1'b1;
                    o_push     = 1'b1;
                    w_cause    = CAUSE_TIMEOUT;
                end
            end else if (w_bad_start) begin
                n_err = sat_inc(r_err);
            end else if (r_pos == POS_W'(LAST_POS)) begin
                n_pos = '0;
                if (!w_end_ok) begin
                    n_err = sat_inc(r_err);
                end else begin
                    n_good     = sat_inc(r_good);
                    n_ch       = w_dec;
                    n_fs       = w_flags[3];
                    n_lost     = w_flags[2];
                    n_lostc    = w_flags[2] ? sat_inc(r_lostc) : r_lostc;
                    n_elapsed  = '0;
                    n_reported = 1'b0;
                    o_push     = 1'b1;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
        o_evt.ch       = n_ch;
        o_evt.failsafe = n_fs;
        o_evt.lost     = n_lost;
        o_evt.good     = n_good;
        o_evt.lostc    = n_lostc;
        o_evt.err      = n_err;
        o_evt.cause    = w_cause;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_ch       <= '0;
            r_fs       <= 1'b0;
            r_lost     <= 1'b0;
            r_elapsed  <= '0;
            r_reported <= 1'b0;
            r_good     <= '0;
            r_lostc    <= '0;
            r_err      <= '0;
        end else begin
            r_pos      <= n_pos;
            r_ch       <= n_ch;
            r_fs       <= n_fs;
            r_lost     <= n_lost;
            r_elapsed  <= n_elapsed;
            r_reported <= n_reported;
            r_good     <= n_good;
            r_lostc    <= n_lostc;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_frame[r_pos] <= i_in.rx_byte;
        end
    end

endmodule

/* design/sfd_queue.sv */
// Short event queue between front end and result sequencer.
module sfd_queue import sfd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_evt,
    input  logic   i_pop,
    output t_event o_evt,
    output logic   o_full,
    output logic   o_empty
);

    t_event              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_evt   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

endmodule

/* design/sfd_back.sv */
// Back end: walks the 18 channels of an event, scales and registers results.
module sfd_back import sfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_event     i_evt,
    input  logic       i_empty,
    input  t_scale_cfg i_cfg,
    output logic       o_pop,
    sfd_out_if.source  o_out
);

    logic             r_busy;
    logic             r_valid;
    logic [IDX_W-1:0] r_idx;
    t_event           r_evt;

    logic                        w_adv;
    logic                        w_last;
    logic                        w_load;
    t_chan                       w_raw;
    logic [CH_W+SCALE_W-1:0]     w_prod;
    logic [CH_W+SCALE_W:0]       w_round;
    logic [CH_W+SCALE_W-FRAC_BITS:0] w_shift;
    logic signed [CH_W+SCALE_W-FRAC_BITS+2:0] w_sum;
    logic [SCALED_W-1:0]         w_scaled;

    assign w_last = (r_idx == IDX_W'(LAST_CH));
    assign w_adv  = r_busy && (!r_valid || o_out.ready);
    assign w_load = !i_empty && (!r_busy || (w_adv && w_last));
    assign o_pop  = w_load;

    always_comb begin
        w_raw   = r_evt.ch[r_idx];
        w_prod  = w_raw * i_cfg.scale;
        w_round = {1'b0, w_prod} + (CH_W+SCALE_W+1)'(1 << (FRAC_BITS-1));
        w_shift = w_round[CH_W+SCALE_W:FRAC_BITS];
        w_sum   = $signed({2'b00, w_shift})
                + (CH_W+SCALE_W-FRAC_BITS+3)'($signed(i_cfg.offset));
        if (w_sum < 0) begin
            w_scaled = '0;
        end else if (w_sum > $signed((CH_W+SCALE_W-FRAC_BITS+3)'({SCALED_W{1'b1}}))) begin
            w_scaled = {SCALED_W{1'b1}};
        end else begin
            w_scaled = w_sum[SCALED_W-1:0];
        end
        if (r_evt.failsafe && r_idx == IDX_W'(THROTTLE_CHANNEL)) begin
            w_scaled = i_cfg.throttle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_adv) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? '0 : r_idx + 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_adv && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_evt <= i_evt;
        end
        if (w_adv) begin
            o_out.channel_index   <= r_idx;
            o_out.raw_value       <= w_raw;
            o_out.scaled_value    <= w_scaled;
            o_out.failsafe_active <= r_evt.failsafe;
            o_out.frame_lost_flag <= r_evt.lost;
            o_out.good_count      <= r_evt.good;
            o_out.lost_count      <= r_evt.lostc;
            o_out.error_count     <= r_evt.err;
            o_out.cause           <= r_evt.cause;
            o_out.last_of_run     <= w_last;
        end
    end

    assign o_out.valid = r_valid;

endmodule

/* design/sbus_frame_decoder_core.sv */
// Top level of the S.BUS frame decoder: config registers, front, queue, back.
//
//  channel   direction  handshake        payload
//  i_in      sink       valid / ready    mode, rx_byte
//  o_out     source     valid / ready    channel_index .. last_of_run
//  i_cfg_*   write      i_cfg_we         i_cfg_idx, i_cfg_data
//
// One input item per cycle while i_in.ready is high; a good frame or a timeout
// yields a run of 18 results, one per cycle from the back end while o_out is ready.
// The event queue holds two runs beside the one in progress; i_in.ready drops
// only while it is full. Results wait in an output register under backpressure.
// Reset is synchronous and clears control state and counters.
module sbus_frame_decoder_core import sfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfd_in_if.sink                i_in,
    sfd_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SCALE_W-1:0]    r_scale;
    logic [OFFSET_W-1:0]   r_offset;
    logic [THROTTLE_W-1:0] r_throttle;
    logic [TIMEOUT_W-1:0]  r_timeout;

    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    t_event     w_push_evt;
    t_event     w_head_evt;
    t_scale_cfg w_scfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= RST_SCALE;
            r_offset   <= RST_OFFSET;
            r_throttle <= RST_THROTTLE;
            r_timeout  <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_SCALE_FACTOR:      r_scale    <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_OFFSET:      r_offset   <= i_cfg_data[OFFSET_W-1:0];
                CFG_FAILSAFE_THROTTLE: r_throttle <= i_cfg_data[THROTTLE_W-1:0];
                CFG_TIMEOUT_MS:        r_timeout  <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_scfg.scale    = r_scale;
    assign w_scfg.offset   = r_offset;
    assign w_scfg.throttle = r_throttle;

    sfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_timeout_ms (r_timeout),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_evt        (w_push_evt)
    );

    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_push_evt),
        .i_pop   (w_pop),
        .o_evt   (w_head_evt),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_head_evt),
        .i_empty (w_empty),
        .i_cfg   (w_scfg),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("event pushed into full queue");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last_of_run |-> o_out.channel_index == IDX_W'(LAST_CH))
        else $error("last item of run has wrong channel index");

    a_timeout_failsafe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.cause |-> o_out.failsafe_active)
        else $error("timeout item without failsafe");

    a_run_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_of_run |=>
            o_out.valid && o_out.channel_index == $past(o_out.channel_index) + 1'b1)
        else $error("run did not advance to the next channel");

endmodule
